/* rtl/bcwq_pkg.sv */
// ----------------------------------------------------------------------------
// bcwq_pkg
// Shared types and constants for the bounded channel with wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

package bcwq_pkg;

  // Fixed field widths at the block boundary
  localparam int ID_W       = 8;
  localparam int VAL_PORT_W = 64;
  localparam int CAP_W      = 5;
  localparam int EV_W       = 4;
  localparam int REQ_W      = 2;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_CAPACITY = 16;
  localparam int unsigned DEF_MAX_WAITERS  = 16;
  localparam int unsigned DEF_VALUE_BITS   = 64;

  // Register map: index is paddr[2]
  localparam logic       REG_CAPACITY   = 1'b0;
  localparam logic [4:0] CAPACITY_RESET = 5'd1;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SEND    = 2'd0,
    REQ_RECV    = 2'd1,
    REQ_CLOSE   = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_e;

  // Result event codes
  typedef enum logic [EV_W-1:0] {
    EV_VALUE         = 4'd0,
    EV_BLOCKED       = 4'd1,
    EV_BUFFERED      = 4'd2,
    EV_WAKE_READER   = 4'd3,
    EV_WAKE_WRITER   = 4'd4,
    EV_SEND_CLOSED   = 4'd5,
    EV_WRITER_CLOSED = 4'd6,
    EV_CLOSE_DONE    = 4'd7,
    EV_QUEUE_FULL    = 4'd8
  } ev_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_CLOSE
  } st_e;

  // Control part of a queued command
  typedef struct packed {
    req_e            op;
    logic [ID_W-1:0] id;
  } cmd_ctl_t;

endpackage

`default_nettype wire

/* rtl/bcwq_ram.sv */
// ----------------------------------------------------------------------------
// bcwq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read (read-before-write)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/bcwq_front.sv */
// ----------------------------------------------------------------------------
// bcwq_front
// Request intake: filters unknown request codes and buffers commands in a
// two-word queue so the back end can work while the next request arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module bcwq_front #(
  parameter int unsigned VALUE_BITS = bcwq_pkg::DEF_VALUE_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bcwq_pkg::REQ_W-1:0]        req_type_i,
  input  wire logic [bcwq_pkg::ID_W-1:0]         requester_id_i,
  input  wire logic [bcwq_pkg::VAL_PORT_W-1:0]   send_value_i,
  output logic                                   cmd_valid_o,
  output bcwq_pkg::cmd_ctl_t                     cmd_ctl_o,
  output logic [VALUE_BITS-1:0]                  cmd_value_o,
  input  wire logic                              cmd_pop_i
);

  bcwq_pkg::cmd_ctl_t    ctl_q [2];
  logic [VALUE_BITS-1:0] val_q [2];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  accept;
  logic                  push;
  bcwq_pkg::req_e        op;

  assign op     = bcwq_pkg::req_e'(req_type_i);
  assign busy   = (cnt_q == 2'd2);
  assign accept = start && !busy;
  // Unknown codes are accepted and dropped here
  assign push   = accept && (op != bcwq_pkg::REQ_UNKNOWN);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push      ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q].op <= op;
      ctl_q[wr_ptr_q].id <= requester_id_i;
      val_q[wr_ptr_q]    <= send_value_i[VALUE_BITS-1:0];
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_ctl_o   = ctl_q[rd_ptr_q];
  assign cmd_value_o = val_q[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/bcwq_back.sv */
// ----------------------------------------------------------------------------
// bcwq_back
// Channel engine: value buffer, blocked-reader and blocked-writer queues,
// closed flag, and the sequencer that turns each command into results.
// ----------------------------------------------------------------------------
`default_nettype none

module bcwq_back #(
  parameter int unsigned MAX_CAPACITY = bcwq_pkg::DEF_MAX_CAPACITY,
  parameter int unsigned MAX_WAITERS  = bcwq_pkg::DEF_MAX_WAITERS,
  parameter int unsigned VALUE_BITS   = bcwq_pkg::DEF_VALUE_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cmd_valid_i,
  input  wire bcwq_pkg::cmd_ctl_t               cmd_ctl_i,
  input  wire logic [VALUE_BITS-1:0]            cmd_value_i,
  output logic                                  cmd_pop_o,
  input  wire logic [bcwq_pkg::CAP_W-1:0]       capacity_i,
  output logic                                  result_strobe_o,
  output logic [bcwq_pkg::EV_W-1:0]             event_res_o,
  output logic [bcwq_pkg::ID_W-1:0]             result_id_o,
  output logic [bcwq_pkg::VAL_PORT_W-1:0]       data_value_o,
  output logic                                  has_value_o,
  output logic                                  last_o
);

  localparam int IDW  = bcwq_pkg::ID_W;
  localparam int VPW  = bcwq_pkg::VAL_PORT_W;
  localparam int VCW  = $clog2(MAX_CAPACITY + 1);
  localparam int VAW  = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int VSW  = VCW + 1;
  localparam int WCW  = $clog2(MAX_WAITERS + 1);
  localparam int WAW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int WSW  = WCW + 1;
  localparam int CMPW = (VCW > bcwq_pkg::CAP_W) ? VCW : bcwq_pkg::CAP_W;
  localparam int WRW  = IDW + VALUE_BITS;

  // Sequencer and command registers
  bcwq_pkg::st_e         state_q, state_d;
  bcwq_pkg::cmd_ctl_t    cmd_q;
  logic [VALUE_BITS-1:0] cmd_value_q;
  logic                  closed_q, closed_d;
  logic [IDW-1:0]        wake_id_q, wake_id_d;

  // Queue pointers and counts
  logic [VAW-1:0] value_head_q, value_head_d, value_tail;
  logic [VCW-1:0] value_count_q, value_count_d;
  logic [WAW-1:0] reader_head_q, reader_head_d, reader_tail;
  logic [WCW-1:0] reader_count_q, reader_count_d;
  logic [WAW-1:0] writer_head_q, writer_head_d, writer_tail;
  logic [WCW-1:0] writer_count_q, writer_count_d;
  logic [VSW-1:0] v_sum;
  logic [WSW-1:0] r_sum, w_sum;

  // Queue operations chosen this cycle
  logic v_push, v_pop, r_push, r_pop, w_push, w_pop;
  logic [VALUE_BITS-1:0] v_wdata;

  // RAM read data
  logic [VALUE_BITS-1:0] value_rdata;
  logic [IDW-1:0]        reader_rdata;
  logic [WRW-1:0]        writer_rdata;
  logic [IDW-1:0]        w_rd_id;
  logic [VALUE_BITS-1:0] w_rd_val;

  // Status
  logic [CMPW-1:0] cap_in, cap_eff;
  logic v_nonempty, r_nonempty, w_nonempty, v_room, r_room, w_room;

  // Result registers
  logic                  res_valid_q, res_valid_d;
  bcwq_pkg::ev_e         res_event_q, res_event_d;
  logic [IDW-1:0]        res_tid_q, res_tid_d;
  logic [VALUE_BITS-1:0] res_data_q, res_data_d;
  logic                  res_hv_q, res_hv_d;
  logic                  res_last_q, res_last_d;

  assign w_rd_id  = writer_rdata[WRW-1:VALUE_BITS];
  assign w_rd_val = writer_rdata[VALUE_BITS-1:0];

  // Status flags; capacity clamps at the buffer depth
  always_comb begin
    cap_in     = CMPW'(capacity_i);
    cap_eff    = (cap_in > CMPW'(MAX_CAPACITY)) ? CMPW'(MAX_CAPACITY) : cap_in;
    v_nonempty = (value_count_q != '0);
    r_nonempty = (reader_count_q != '0);
    w_nonempty = (writer_count_q != '0);
    v_room     = (CMPW'(value_count_q) < cap_eff);
    r_room     = (reader_count_q < WCW'(MAX_WAITERS));
    w_room     = (writer_count_q < WCW'(MAX_WAITERS));
  end

  // Tail slots: head + count, one wrap at most
  always_comb begin
    v_sum = VSW'(value_head_q) + VSW'(value_count_q);
    r_sum = WSW'(reader_head_q) + WSW'(reader_count_q);
    w_sum = WSW'(writer_head_q) + WSW'(writer_count_q);
    value_tail  = (v_sum >= VSW'(MAX_CAPACITY)) ? VAW'(v_sum - VSW'(MAX_CAPACITY))
                                                : VAW'(v_sum);
    reader_tail = (r_sum >= WSW'(MAX_WAITERS)) ? WAW'(r_sum - WSW'(MAX_WAITERS))
                                               : WAW'(r_sum);
    writer_tail = (w_sum >= WSW'(MAX_WAITERS)) ? WAW'(w_sum - WSW'(MAX_WAITERS))
                                               : WAW'(w_sum);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcwq_pkg::ST_IDLE: begin
        if (cmd_valid_i) state_d = bcwq_pkg::ST_EXEC;
      end
      bcwq_pkg::ST_EXEC: begin
        unique case (cmd_q.op)
          bcwq_pkg::REQ_SEND:  state_d = bcwq_pkg::ST_IDLE;
          bcwq_pkg::REQ_RECV:  state_d = w_nonempty ? bcwq_pkg::ST_WAKE : bcwq_pkg::ST_IDLE;
          default:             state_d = bcwq_pkg::ST_CLOSE;
        endcase
      end
      bcwq_pkg::ST_WAKE: begin
        state_d = bcwq_pkg::ST_IDLE;
      end
      bcwq_pkg::ST_CLOSE: begin
        if (!r_nonempty && !w_nonempty) state_d = bcwq_pkg::ST_IDLE;
      end
      default: state_d = bcwq_pkg::ST_IDLE;
    endcase
  end

  // Outputs: queue operations, flags and the result word
  always_comb begin
    cmd_pop_o   = 1'b0;
    v_push      = 1'b0;
    v_pop       = 1'b0;
    r_push      = 1'b0;
    r_pop       = 1'b0;
    w_push      = 1'b0;
    w_pop       = 1'b0;
    v_wdata     = cmd_value_q;
    closed_d    = closed_q;
    wake_id_d   = wake_id_q;
    res_valid_d = 1'b0;
    res_event_d = bcwq_pkg::EV_VALUE;
    res_tid_d   = cmd_q.id;
    res_data_d  = '0;
    res_hv_d    = 1'b0;
    res_last_d  = 1'b1;
    unique case (state_q)
      bcwq_pkg::ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
      end
      bcwq_pkg::ST_EXEC: begin
        res_valid_d = 1'b1;
        unique case (cmd_q.op)
          bcwq_pkg::REQ_SEND: begin
            priority if (closed_q) begin
              res_event_d = bcwq_pkg::EV_SEND_CLOSED;
            end else if (r_nonempty) begin
              // hand the value straight to the oldest reader
              r_pop       = 1'b1;
              res_event_d = bcwq_pkg::EV_WAKE_READER;
              res_tid_d   = reader_rdata;
              res_data_d  = cmd_value_q;
              res_hv_d    = 1'b1;
            end else if (v_room) begin
              v_push      = 1'b1;
              res_event_d = bcwq_pkg::EV_BUFFERED;
            end else if (w_room) begin
              w_push      = 1'b1;
              res_event_d = bcwq_pkg::EV_BLOCKED;
            end else begin
              res_event_d = bcwq_pkg::EV_QUEUE_FULL;
            end
          end
          bcwq_pkg::REQ_RECV: begin
            priority if (v_nonempty) begin
              v_pop       = 1'b1;
              res_event_d = bcwq_pkg::EV_VALUE;
              res_data_d  = value_rdata;
              res_hv_d    = 1'b1;
              // refill the buffer from the oldest blocked writer
              if (w_nonempty) begin
                w_pop      = 1'b1;
                v_push     = 1'b1;
                v_wdata    = w_rd_val;
                wake_id_d  = w_rd_id;
                res_last_d = 1'b0;
              end
            end else if (w_nonempty) begin
              w_pop       = 1'b1;
              wake_id_d   = w_rd_id;
              res_event_d = bcwq_pkg::EV_VALUE;
              res_data_d  = w_rd_val;
              res_hv_d    = 1'b1;
              res_last_d  = 1'b0;
            end else if (closed_q) begin
              res_event_d = bcwq_pkg::EV_VALUE;
            end else if (r_room) begin
              r_push      = 1'b1;
              res_event_d = bcwq_pkg::EV_BLOCKED;
            end else begin
              res_event_d = bcwq_pkg::EV_QUEUE_FULL;
            end
          end
          default: begin
            // close: flag now, drain the waiters next
            closed_d    = 1'b1;
            res_valid_d = 1'b0;
          end
        endcase
      end
      bcwq_pkg::ST_WAKE: begin
        res_valid_d = 1'b1;
        res_event_d = bcwq_pkg::EV_WAKE_WRITER;
        res_tid_d   = wake_id_q;
      end
      bcwq_pkg::ST_CLOSE: begin
        res_valid_d = 1'b1;
        priority if (r_nonempty) begin
          r_pop       = 1'b1;
          res_event_d = bcwq_pkg::EV_WAKE_READER;
          res_tid_d   = reader_rdata;
          res_last_d  = 1'b0;
        end else if (w_nonempty) begin
          w_pop       = 1'b1;
          res_event_d = bcwq_pkg::EV_WRITER_CLOSED;
          res_tid_d   = w_rd_id;
          res_last_d  = 1'b0;
        end else begin
          res_event_d = bcwq_pkg::EV_CLOSE_DONE;
        end
      end
      default: ;
    endcase
  end

  // Pointer and count updates
  always_comb begin
    value_head_d   = value_head_q;
    reader_head_d  = reader_head_q;
    writer_head_d  = writer_head_q;
    if (v_pop) begin
      value_head_d = (value_head_q == VAW'(MAX_CAPACITY - 1)) ? '0 : value_head_q + 1'b1;
    end
    if (r_pop) begin
      reader_head_d = (reader_head_q == WAW'(MAX_WAITERS - 1)) ? '0 : reader_head_q + 1'b1;
    end
    if (w_pop) begin
      writer_head_d = (writer_head_q == WAW'(MAX_WAITERS - 1)) ? '0 : writer_head_q + 1'b1;
    end
    value_count_d  = value_count_q + VCW'(v_push) - VCW'(v_pop);
    reader_count_d = reader_count_q + WCW'(r_push) - WCW'(r_pop);
    writer_count_d = writer_count_q + WCW'(w_push) - WCW'(w_pop);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bcwq_pkg::ST_IDLE;
      closed_q       <= 1'b0;
      value_head_q   <= '0;
      value_count_q  <= '0;
      reader_head_q  <= '0;
      reader_count_q <= '0;
      writer_head_q  <= '0;
      writer_count_q <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      closed_q       <= closed_d;
      value_head_q   <= value_head_d;
      value_count_q  <= value_count_d;
      reader_head_q  <= reader_head_d;
      reader_count_q <= reader_count_d;
      writer_head_q  <= writer_head_d;
      writer_count_q <= writer_count_d;
      res_valid_q    <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q       <= cmd_ctl_i;
      cmd_value_q <= cmd_value_i;
    end
    wake_id_q   <= wake_id_d;
    res_event_q <= res_event_d;
    res_tid_q   <= res_tid_d;
    res_data_q  <= res_data_d;
    res_hv_q    <= res_hv_d;
    res_last_q  <= res_last_d;
  end

  // Storage; read addresses follow the next head so data tracks the head
  bcwq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (v_push),
    .waddr_i (value_tail),
    .wdata_i (v_wdata),
    .raddr_i (value_head_d),
    .rdata_o (value_rdata)
  );

  bcwq_ram #(
    .WIDTH (IDW),
    .DEPTH (MAX_WAITERS)
  ) u_reader_ram (
    .clk_i   (clk_i),
    .we_i    (r_push),
    .waddr_i (reader_tail),
    .wdata_i (cmd_q.id),
    .raddr_i (reader_head_d),
    .rdata_o (reader_rdata)
  );

  bcwq_ram #(
    .WIDTH (WRW),
    .DEPTH (MAX_WAITERS)
  ) u_writer_ram (
    .clk_i   (clk_i),
    .we_i    (w_push),
    .waddr_i (writer_tail),
    .wdata_i ({cmd_q.id, cmd_value_q}),
    .raddr_i (writer_head_d),
    .rdata_o (writer_rdata)
  );

  assign result_strobe_o = res_valid_q;
  assign event_res_o     = res_event_q;
  assign result_id_o     = res_tid_q;
  assign data_value_o    = VPW'(res_data_q);
  assign has_value_o     = res_hv_q;
  assign last_o          = res_last_q;

endmodule

`default_nettype wire

/* rtl/bounded_channel_with_wait_queues.sv */
// ----------------------------------------------------------------------------
// bounded_channel_with_wait_queues
// Message channel between threads with a bounded value buffer and queues of
// blocked readers and blocked writers.
// ----------------------------------------------------------------------------
// A request (send, receive or close) is taken when start is high and busy is
// low; a two-word command queue in front lets up to two requests wait while
// the engine works. The engine first loads a command and then executes it; a
// receive that also wakes a blocked writer gives a second result for the
// wake, and a close releases each waiter it holds, one result per cycle,
// and ends with a close-done result. Each result
// is shown for exactly one cycle with result_strobe_o and cannot be held
// off, so the receiver must take it in that cycle. last_o marks the final
// result of a request. Requests with the unknown code 3 are taken and give
// no result. buffer_capacity is written through the APB port at address 0
// and should only change while the channel is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_channel_with_wait_queues #(
  parameter int unsigned MAX_CAPACITY = bcwq_pkg::DEF_MAX_CAPACITY,
  parameter int unsigned MAX_WAITERS  = bcwq_pkg::DEF_MAX_WAITERS,
  parameter int unsigned VALUE_BITS   = bcwq_pkg::DEF_VALUE_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command interface
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bcwq_pkg::REQ_W-1:0]      req_type_i,
  input  wire logic [bcwq_pkg::ID_W-1:0]       requester_id_i,
  input  wire logic [bcwq_pkg::VAL_PORT_W-1:0] send_value_i,
  // results
  output logic                                 result_strobe_o,
  output logic [bcwq_pkg::EV_W-1:0]            event_res_o,
  output logic [bcwq_pkg::ID_W-1:0]            result_id_o,
  output logic [bcwq_pkg::VAL_PORT_W-1:0]      data_value_o,
  output logic                                 has_value_o,
  output logic                                 last_o,
  // APB configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bcwq_pkg::APB_AW-1:0]     paddr,
  input  wire logic [bcwq_pkg::APB_DW-1:0]     pwdata,
  output logic [bcwq_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  localparam int DW = bcwq_pkg::APB_DW;

  logic [bcwq_pkg::CAP_W-1:0] capacity_q, capacity_d;
  logic                       cfg_wr;
  logic                       cmd_valid;
  logic                       cmd_pop;
  bcwq_pkg::cmd_ctl_t         cmd_ctl;
  logic [VALUE_BITS-1:0]      cmd_value;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == bcwq_pkg::REG_CAPACITY);

  always_comb begin
    capacity_d = cfg_wr ? pwdata[bcwq_pkg::CAP_W-1:0] : capacity_q;
    prdata     = (paddr[2] == bcwq_pkg::REG_CAPACITY) ? DW'(capacity_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= bcwq_pkg::CAPACITY_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  // Request intake
  bcwq_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .requester_id_i (requester_id_i),
    .send_value_i   (send_value_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ctl_o      (cmd_ctl),
    .cmd_value_o    (cmd_value),
    .cmd_pop_i      (cmd_pop)
  );

  // Channel engine
  bcwq_back #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .MAX_WAITERS  (MAX_WAITERS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ctl_i       (cmd_ctl),
    .cmd_value_i     (cmd_value),
    .cmd_pop_o       (cmd_pop),
    .capacity_i      (capacity_q),
    .result_strobe_o (result_strobe_o),
    .event_res_o     (event_res_o),
    .result_id_o     (result_id_o),
    .data_value_o    (data_value_o),
    .has_value_o     (has_value_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
